/* sv/kmp_pkg.sv */
// Shared constants and register codes for the streaming KMP pattern matcher.
package kmp_pkg;

    // Pattern bytes held by the two 64-bit pattern registers
    localparam int unsigned PAT_BYTES     = 16;
    localparam int unsigned CFG_DATA_BITS = 64;
    localparam int unsigned LEN_BITS      = 5;
    localparam int unsigned SKIP_BITS     = 20;
    localparam int unsigned START_BITS    = 20;
    localparam int unsigned BYTE_BITS     = 8;

    // Configuration register indexes
    typedef enum logic [1:0] {
        CFG_PATTERN_LOW    = 2'd0,
        CFG_PATTERN_HIGH   = 2'd1,
        CFG_PATTERN_LENGTH = 2'd2,
        CFG_SKIP_COUNT     = 2'd3
    } cfg_index_t;

endpackage

/* sv/kmp_pattern_matcher.sv */
// Streaming KMP matcher: failure table in a synchronous RAM, build and match sequencer.
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+------------------------------------
//   in      | sink      | in_valid / in_stall  | text_byte, first_byte, last_byte
//   out     | source    | out_valid / out_stall| found, match_start, not_found
//   cfg     | sink      | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// A request is taken in ST_IDLE and compared in ST_MATCH_CMP; each failure link
// followed for that byte is one read of the failure RAM through its registered port.
// After reset and after every configuration write the failure table is rebuilt for
// the clamped pattern length with in_stall high, one RAM read per link followed.
// A finished result sits in the output register while the next request is taken;
// a request only waits at its final step if that register is still stalled.
module kmp_pattern_matcher
    import kmp_pkg::*;
#(
    parameter int unsigned MAX_PATTERN   = 16,
    parameter int unsigned POSITION_BITS = 20
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    // text requests
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic [BYTE_BITS-1:0]     text_byte,
    input  logic                     first_byte,
    input  logic                     last_byte,
    // results
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic                     found,
    output logic [START_BITS-1:0]    match_start,
    output logic                     not_found,
    // configuration writes
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  cfg_index_t               cfg_index,
    input  logic [CFG_DATA_BITS-1:0] cfg_data
);

    localparam int unsigned LEN_W = $clog2(MAX_PATTERN + 1);
    localparam int unsigned IDX_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
    localparam int unsigned EXT_W = (POSITION_BITS > START_BITS) ? POSITION_BITS
                                                                 : START_BITS;

    typedef enum logic [2:0] {
        ST_BUILD_INIT,
        ST_BUILD_CMP,
        ST_BUILD_WAIT,
        ST_IDLE,
        ST_MATCH_CMP,
        ST_MATCH_WAIT
    } state_t;

    // configuration registers
    logic [CFG_DATA_BITS-1:0] pat_low_reg, pat_low_next;
    logic [CFG_DATA_BITS-1:0] pat_high_reg, pat_high_next;
    logic [LEN_BITS-1:0]      length_reg, length_next;
    logic [SKIP_BITS-1:0]     skip_reg, skip_next;

    // control and search state
    state_t                   state_reg, state_next;
    logic [LEN_W-1:0]         matched_reg, matched_next;
    logic [POSITION_BITS-1:0] pos_reg, pos_next;
    logic                     done_reg, done_next;
    logic [LEN_W-1:0]         j_reg, j_next;
    logic [IDX_W-1:0]         bi_reg, bi_next;
    logic [IDX_W-1:0]         bk_reg, bk_next;

    // current request payload
    logic [BYTE_BITS-1:0]     c_reg, c_next;
    logic                     last_reg, last_next;

    // result register
    logic                     out_valid_reg, out_valid_next;
    logic                     found_reg, found_next;
    logic [START_BITS-1:0]    start_reg, start_next;
    logic                     not_found_reg, not_found_next;

    // failure table RAM
    logic [IDX_W-1:0]         fail_mem [MAX_PATTERN];
    logic                     mem_we;
    logic [IDX_W-1:0]         mem_waddr;
    logic [IDX_W-1:0]         mem_wdata;
    logic                     mem_re;
    logic [IDX_W-1:0]         mem_raddr;
    logic [IDX_W-1:0]         mem_rdata_reg;

    // derived values
    logic [2*CFG_DATA_BITS-1:0] pat_all;
    logic [BYTE_BITS-1:0]     pat_arr [MAX_PATTERN];
    logic [LEN_W-1:0]         n_eff;
    logic [EXT_W-1:0]         pos_ext;
    logic                     pos_ge_skip;
    logic [POSITION_BITS-1:0] pos_inc;
    logic                     slot_free;
    logic [LEN_W-1:0]         j_m1;
    logic [LEN_W-1:0]         bk_m1;
    logic [LEN_W-1:0]         j_adv;
    logic [IDX_W-1:0]         bk_adv;
    logic                     j_hit;
    logic                     bk_hit;

    assign pat_all = {pat_high_reg, pat_low_reg};

    // unpack pattern bytes; bytes past the register pair read as zero
    for (genvar gi = 0; gi < MAX_PATTERN; gi++) begin : g_pat
        if (gi < PAT_BYTES) begin : g_used
            assign pat_arr[gi] = pat_all[gi*BYTE_BITS +: BYTE_BITS];
        end
        else begin : g_zero
            assign pat_arr[gi] = '0;
        end
    end

    // clamp the pattern length into 1..MAX_PATTERN
    always_comb
    begin
        if (length_reg == '0)
            n_eff = LEN_W'(1);
        else if (32'(length_reg) > MAX_PATTERN)
            n_eff = LEN_W'(MAX_PATTERN);
        else
            n_eff = LEN_W'(length_reg);
    end

    assign pos_ext     = EXT_W'(pos_reg);
    assign pos_ge_skip = pos_ext >= EXT_W'(skip_reg);
    assign pos_inc     = (pos_reg == '1) ? pos_reg : pos_reg + 1'b1;
    assign slot_free   = !out_valid_reg || !out_stall;

    assign j_m1   = j_reg - 1'b1;
    assign bk_m1  = LEN_W'(bk_reg) - 1'b1;
    assign j_hit  = pat_arr[j_reg[IDX_W-1:0]] == c_reg;
    assign bk_hit = pat_arr[bk_reg] == pat_arr[bi_reg];
    assign j_adv  = j_reg + LEN_W'(j_hit);
    assign bk_adv = bk_reg + IDX_W'(bk_hit);

    assign in_stall    = (state_reg != ST_IDLE) || cfg_valid;
    assign cfg_ready   = 1'b1;
    assign out_valid   = out_valid_reg;
    assign found       = found_reg;
    assign match_start = start_reg;
    assign not_found   = not_found_reg;

    // sequencer: failure table build and per-byte match
    always_comb
    begin
        pat_low_next   = pat_low_reg;
        pat_high_next  = pat_high_reg;
        length_next    = length_reg;
        skip_next      = skip_reg;
        state_next     = state_reg;
        matched_next   = matched_reg;
        pos_next       = pos_reg;
        done_next      = done_reg;
        j_next         = j_reg;
        bi_next        = bi_reg;
        bk_next        = bk_reg;
        c_next         = c_reg;
        last_next      = last_reg;
        out_valid_next = out_valid_reg;
        found_next     = found_reg;
        start_next     = start_reg;
        not_found_next = not_found_reg;
        mem_we         = 1'b0;
        mem_waddr      = '0;
        mem_wdata      = '0;
        mem_re         = 1'b0;
        mem_raddr      = '0;

        // drop a result once taken
        if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;

        if (cfg_valid) begin
            // store the register and restart the table build
            unique case (cfg_index)
                CFG_PATTERN_LOW:    pat_low_next  = cfg_data;
                CFG_PATTERN_HIGH:   pat_high_next = cfg_data;
                CFG_PATTERN_LENGTH: length_next   = cfg_data[LEN_BITS-1:0];
                CFG_SKIP_COUNT:     skip_next     = cfg_data[SKIP_BITS-1:0];
            endcase
            state_next = ST_BUILD_INIT;
        end
        else begin
            unique case (state_reg)
                ST_BUILD_INIT:
                begin
                    mem_we    = 1'b1;
                    mem_waddr = '0;
                    mem_wdata = '0;
                    if (n_eff == LEN_W'(1))
                        state_next = ST_IDLE;
                    else begin
                        bi_next    = IDX_W'(1);
                        bk_next    = '0;
                        state_next = ST_BUILD_CMP;
                    end
                end
                ST_BUILD_CMP:
                begin
                    if (bk_reg != '0 && !bk_hit) begin
                        // follow the failure link of the prefix
                        mem_re     = 1'b1;
                        mem_raddr  = bk_m1[IDX_W-1:0];
                        state_next = ST_BUILD_WAIT;
                    end
                    else begin
                        mem_we    = 1'b1;
                        mem_waddr = bi_reg;
                        mem_wdata = bk_adv;
                        bk_next   = bk_adv;
                        if (LEN_W'(bi_reg) == n_eff - 1'b1)
                            state_next = ST_IDLE;
                        else
                            bi_next = bi_reg + 1'b1;
                    end
                end
                ST_BUILD_WAIT:
                begin
                    bk_next    = mem_rdata_reg;
                    state_next = ST_BUILD_CMP;
                end
                ST_IDLE:
                begin
                    if (in_valid) begin
                        c_next    = text_byte;
                        last_next = last_byte;
                        if (first_byte) begin
                            matched_next = '0;
                            pos_next     = '0;
                            done_next    = 1'b0;
                            j_next       = '0;
                        end
                        else if (matched_reg >= n_eff)
                            j_next = '0;
                        else
                            j_next = matched_reg;
                        state_next = ST_MATCH_CMP;
                    end
                end
                ST_MATCH_CMP:
                begin
                    if (done_reg) begin
                        // search finished: all-zero result
                        if (slot_free) begin
                            out_valid_next = 1'b1;
                            found_next     = 1'b0;
                            start_next     = '0;
                            not_found_next = 1'b0;
                            state_next     = ST_IDLE;
                        end
                    end
                    else if (!pos_ge_skip) begin
                        // byte inside the skipped region
                        if (slot_free) begin
                            out_valid_next = 1'b1;
                            found_next     = 1'b0;
                            start_next     = '0;
                            not_found_next = last_reg;
                            if (last_reg) begin
                                done_next    = 1'b1;
                                matched_next = '0;
                            end
                            pos_next   = pos_inc;
                            state_next = ST_IDLE;
                        end
                    end
                    else if (j_reg != '0 && !j_hit) begin
                        // mismatch: fetch the failure link
                        mem_re     = 1'b1;
                        mem_raddr  = j_m1[IDX_W-1:0];
                        state_next = ST_MATCH_WAIT;
                    end
                    else if (slot_free) begin
                        out_valid_next = 1'b1;
                        pos_next       = pos_inc;
                        state_next     = ST_IDLE;
                        if (j_adv >= n_eff) begin
                            found_next     = 1'b1;
                            start_next     = pos_ext[START_BITS-1:0] + 1'b1
                                             - START_BITS'(n_eff);
                            not_found_next = 1'b0;
                            matched_next   = '0;
                            done_next      = 1'b1;
                        end
                        else begin
                            found_next     = 1'b0;
                            start_next     = '0;
                            not_found_next = last_reg;
                            if (last_reg) begin
                                done_next    = 1'b1;
                                matched_next = '0;
                            end
                            else
                                matched_next = j_adv;
                        end
                    end
                end
                ST_MATCH_WAIT:
                begin
                    j_next     = LEN_W'(mem_rdata_reg);
                    state_next = ST_MATCH_CMP;
                end
                default:
                begin
                    state_next = ST_IDLE;
                end
            endcase
        end
    end

    // hold configuration, control state and the result valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            pat_low_reg   <= '0;
            pat_high_reg  <= '0;
            length_reg    <= LEN_BITS'(1);
            skip_reg      <= '0;
            state_reg     <= ST_BUILD_INIT;
            matched_reg   <= '0;
            pos_reg       <= '0;
            done_reg      <= 1'b0;
            j_reg         <= '0;
            bi_reg        <= '0;
            bk_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else begin
            pat_low_reg   <= pat_low_next;
            pat_high_reg  <= pat_high_next;
            length_reg    <= length_next;
            skip_reg      <= skip_next;
            state_reg     <= state_next;
            matched_reg   <= matched_next;
            pos_reg       <= pos_next;
            done_reg      <= done_next;
            j_reg         <= j_next;
            bi_reg        <= bi_next;
            bk_reg        <= bk_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        c_reg         <= c_next;
        last_reg      <= last_next;
        found_reg     <= found_next;
        start_reg     <= start_next;
        not_found_reg <= not_found_next;
    end

    // failure table RAM, one write and one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
            fail_mem[mem_waddr] <= mem_wdata;
        if (mem_re)
            mem_rdata_reg <= fail_mem[mem_raddr];
    end

`ifndef SYNTHESIS
    a_found_excl: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(found && not_found))
        else $error("found and not_found both set");

    a_accept_to_match: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> state_reg == ST_MATCH_CMP)
        else $error("accepted request did not enter match");

    a_cfg_rebuild: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid && cfg_ready |=> state_reg == ST_BUILD_INIT)
        else $error("config write did not restart table build");

    a_j_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_MATCH_CMP |-> j_reg < n_eff)
        else $error("match count out of range");

    a_found_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) && found_reg |-> done_reg)
        else $error("match reported without ending the search");
`endif

endmodule

/* bench/kmp_pattern_matcher_test.sv */
// Self-checking bench for the streaming KMP matcher: directed and random texts, scoreboard.
module kmp_pattern_matcher_test
    import kmp_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned QUIET_LIMIT  = 20000;
    localparam int unsigned TAIL_CYCLES  = 60;
    localparam int unsigned RANDOM_ITEMS = 500;
    localparam int unsigned PRINT_CAP    = 40;

    typedef struct packed {
        logic [BYTE_BITS-1:0] text;
        logic                 first;
        logic                 last;
    } text_req_t;

    typedef struct packed {
        logic                  found;
        logic [START_BITS-1:0] start;
        logic                  not_found;
    } match_result_t;

    // DUT connections, all inputs known from time zero
    logic                     clk         = 1'b0;
    logic                     rst_n       = 1'b0;
    logic                     in_valid    = 1'b0;
    logic                     in_stall;
    logic [BYTE_BITS-1:0]     text_byte   = '0;
    logic                     first_byte  = 1'b0;
    logic                     last_byte   = 1'b0;
    logic                     out_valid;
    logic                     out_stall   = 1'b0;
    logic                     found;
    logic [START_BITS-1:0]    match_start;
    logic                     not_found;
    logic                     cfg_valid   = 1'b0;
    logic                     cfg_ready;
    cfg_index_t               cfg_index   = CFG_PATTERN_LOW;
    logic [CFG_DATA_BITS-1:0] cfg_data    = '0;

    // Stimulus and scoreboard storage
    text_req_t     text_queue[$];
    match_result_t pending_results[$];
    int unsigned   send_gap_pct   = 0;
    int unsigned   recv_stall_pct = 0;
    int unsigned   error_count    = 0;
    int unsigned   items_sent     = 0;
    int unsigned   results_seen   = 0;
    int unsigned   hits_seen      = 0;
    int unsigned   misses_seen    = 0;
    int unsigned   cfg_writes     = 0;
    int unsigned   quiet_cycles   = 0;
    logic [7:0]    text_alphabet [3];

    // Matcher model: registers and search state
    logic [63:0]   model_pat_low;
    logic [63:0]   model_pat_high;
    logic [4:0]    model_len;
    logic [19:0]   model_skip;
    logic [4:0]    link_table [PAT_BYTES];
    logic [4:0]    run_matched;
    logic [19:0]   run_pos;
    logic          run_done;

    kmp_pattern_matcher u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .text_byte   (text_byte),
        .first_byte  (first_byte),
        .last_byte   (last_byte),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .found       (found),
        .match_start (match_start),
        .not_found   (not_found),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic logic [7:0] pattern_byte(input logic [4:0] idx);
        logic [127:0] whole;
        whole = {model_pat_high, model_pat_low};
        if (idx >= PAT_BYTES)
            return 8'h00;
        return whole[idx[3:0]*8 +: 8];
    endfunction

    // Zero acts as one, anything above the table size as the table size
    function automatic logic [4:0] active_length();
        if (model_len == 5'd0)
            return 5'd1;
        if (model_len > PAT_BYTES)
            return 5'(PAT_BYTES);
        return model_len;
    endfunction

    // Rebuild the prefix links for the active pattern
    function automatic void rebuild_links();
        logic [4:0] n;
        logic [4:0] k;
        int         i;
        n = active_length();
        k = 5'd0;
        for (i = 0; i < PAT_BYTES; i++)
            link_table[i] = 5'd0;
        for (i = 1; i < n; i++)
        begin
            while (k != 5'd0 && pattern_byte(k) != pattern_byte(5'(i)))
                k = link_table[k - 5'd1];
            if (pattern_byte(k) == pattern_byte(5'(i)))
                k = k + 5'd1;
            link_table[i] = k;
        end
    endfunction

    function automatic void apply_reg(input cfg_index_t idx, input logic [63:0] data);
        case (idx)
            CFG_PATTERN_LOW:    model_pat_low  = data;
            CFG_PATTERN_HIGH:   model_pat_high = data;
            CFG_PATTERN_LENGTH: model_len      = data[4:0];
            CFG_SKIP_COUNT:     model_skip     = data[19:0];
            default: ;
        endcase
        rebuild_links();
    endfunction

    // Advance the search by one text byte and return the result it gives
    function automatic match_result_t search_step(input logic [7:0] c,
                                                  input logic first,
                                                  input logic last);
        match_result_t r;
        logic [4:0]    n;
        logic [4:0]    j;
        logic [19:0]   pos;
        r = '0;
        if (first)
        begin
            run_matched = 5'd0;
            run_pos     = 20'd0;
            run_done    = 1'b0;
        end
        if (run_done)
            return r;
        pos = run_pos;
        if (run_pos != '1)
            run_pos = run_pos + 20'd1;
        n = active_length();
        if (pos >= model_skip)
        begin
            j = run_matched;
            if (j >= n)
                j = 5'd0;
            while (j != 5'd0 && pattern_byte(j) != c)
                j = link_table[j - 5'd1];
            if (pattern_byte(j) == c)
                j = j + 5'd1;
            if (j >= n)
            begin
                r.found     = 1'b1;
                r.start     = pos + 20'd1 - 20'(n);
                run_matched = 5'd0;
                run_done    = 1'b1;
                return r;
            end
            run_matched = j;
        end
        if (last)
        begin
            r.not_found = 1'b1;
            run_matched = 5'd0;
            run_done    = 1'b1;
        end
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        if (error_count < PRINT_CAP)
            $display("[%0t] mismatch on result %0d: %s", $time, results_seen, msg);
        error_count++;
    endtask

    // Driver: present queued requests, predict each one as it is taken
    always @(posedge clk or negedge rst_n)
    begin : drive_requests
        text_req_t next_req;
        if (!rst_n)
        begin
            in_valid   <= 1'b0;
            text_byte  <= '0;
            first_byte <= 1'b0;
            last_byte  <= 1'b0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                pending_results.push_back(search_step(text_byte, first_byte, last_byte));
                items_sent++;
            end
            if (!in_valid || !in_stall)
            begin
                if (text_queue.size() != 0 && $urandom_range(0, 99) >= send_gap_pct)
                begin
                    next_req   = text_queue.pop_front();
                    in_valid   <= 1'b1;
                    text_byte  <= next_req.text;
                    first_byte <= next_req.first;
                    last_byte  <= next_req.last;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: check each taken result against the oldest prediction
    always @(posedge clk or negedge rst_n)
    begin : check_results
        match_result_t want;
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (pending_results.size() == 0)
                begin
                    report_mismatch("result with no request outstanding");
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (found !== want.found)
                        report_mismatch($sformatf("found %b, expected %b",
                                                  found, want.found));
                    if (match_start !== want.start)
                        report_mismatch($sformatf("match_start %0d, expected %0d",
                                                  match_start, want.start));
                    if (not_found !== want.not_found)
                        report_mismatch($sformatf("not_found %b, expected %b",
                                                  not_found, want.not_found));
                end
                if (found === 1'b1)
                    hits_seen++;
                if (not_found === 1'b1)
                    misses_seen++;
                results_seen++;
            end
            out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
        end
    end

    // Watchdog: end the run when nothing moves for too long
    always @(posedge clk)
    begin : watchdog
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
            (cfg_valid && cfg_ready))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("[%0t] no progress for %0d cycles", $time, QUIET_LIMIT);
            $display("simulation failed");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic queue_byte(input logic [7:0] c, input logic first, input logic last);
        text_req_t req;
        req.text  = c;
        req.first = first;
        req.last  = last;
        text_queue.push_back(req);
    endtask

    // Hold until every request is taken and every result has come back
    task automatic wait_idle();
        do
            @(posedge clk);
        while (text_queue.size() != 0 || in_valid || pending_results.size() != 0);
    endtask

    task automatic write_reg(input cfg_index_t idx, input logic [63:0] data);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        apply_reg(idx, data);
        cfg_writes++;
    endtask

    // Pick a pattern over a small alphabet so that random texts hit it often
    task automatic configure_segment(input int unsigned seg);
        logic [63:0] lo;
        logic [63:0] hi;
        logic [4:0]  len;
        logic [19:0] skip;
        int          i;
        for (i = 0; i < 3; i++)
            text_alphabet[i] = 8'($urandom_range(0, 255));
        for (i = 0; i < 8; i++)
        begin
            lo[i*8 +: 8] = text_alphabet[$urandom_range(0, 2)];
            hi[i*8 +: 8] = text_alphabet[$urandom_range(0, 2)];
        end
        if ($urandom_range(0, 3) == 0)
            len = 5'($urandom_range(1, 16));
        else
            len = 5'($urandom_range(1, 5));
        if ($urandom_range(0, 3) == 0)
            skip = 20'($urandom_range(0, 25));
        else
            skip = 20'($urandom_range(0, 4));
        case (seg % 6)
            0:
            begin
                len  = 5'd16;
                skip = 20'd0;
            end
            1: len = 5'd0;
            2:
            begin
                lo               = '1;
                hi               = '1;
                len              = 5'd31;
                text_alphabet[0] = 8'hFF;
                text_alphabet[1] = 8'hFF;
            end
            3: skip = 20'hFFFFF;
            default: ;
        endcase
        write_reg(CFG_PATTERN_LOW, lo);
        write_reg(CFG_PATTERN_HIGH, hi);
        write_reg(CFG_PATTERN_LENGTH, 64'(len));
        write_reg(CFG_SKIP_COUNT, 64'(skip));
    endtask

    // Queue one text, mostly well formed, sometimes with the pattern planted
    task automatic queue_text(inout int unsigned count);
        logic [7:0]  body [64];
        int unsigned len;
        int unsigned at;
        int unsigned i;
        logic [4:0]  n;
        logic        first_ok;
        logic        last_ok;
        len = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 48) : $urandom_range(1, 30);
        n   = active_length();
        for (i = 0; i < len; i++)
            body[i] = ($urandom_range(0, 9) < 8) ? text_alphabet[$urandom_range(0, 2)]
                                                  : 8'($urandom_range(0, 255));
        if ($urandom_range(0, 1) == 1 && len >= n)
        begin
            at = $urandom_range(0, len - n);
            for (i = 0; i < n; i++)
                body[at + i] = pattern_byte(5'(i));
        end
        first_ok = ($urandom_range(0, 9) != 0);
        last_ok  = ($urandom_range(0, 9) != 0);
        for (i = 0; i < len; i++)
            queue_byte(body[i], first_ok && i == 0, last_ok && i == len - 1);
        count += len;
    endtask

    // Queue raw bytes with random flags
    task automatic queue_noise(input int unsigned k, inout int unsigned count);
        int unsigned i;
        for (i = 0; i < k; i++)
            queue_byte(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0,
                       $urandom_range(0, 7) == 0);
        count += k;
    endtask

    initial
    begin : stimulus
        int unsigned random_count;
        int unsigned seg;
        int unsigned t;

        model_pat_low  = '0;
        model_pat_high = '0;
        model_len      = 5'd1;
        model_skip     = '0;
        run_matched    = '0;
        run_pos        = '0;
        run_done       = 1'b0;
        rebuild_links();
        random_count   = 0;
        seg            = 0;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: reset pattern is a single zero byte
        send_gap_pct   = 6;
        recv_stall_pct = 50;
        queue_byte(8'hFF, 1'b1, 1'b0);
        queue_byte(8'h00, 1'b0, 1'b0);
        queue_byte(8'h00, 1'b0, 1'b1);
        queue_byte(8'h5A, 1'b1, 1'b1);
        queue_byte(8'h00, 1'b0, 1'b0);
        wait_idle();

        // Directed: "ABABC" with two skipped bytes, failure links taken on the way
        write_reg(CFG_PATTERN_LOW, 64'hFFFF_FF43_4241_4241);
        write_reg(CFG_PATTERN_HIGH, '1);
        write_reg(CFG_PATTERN_LENGTH, 64'd5);
        write_reg(CFG_SKIP_COUNT, 64'd2);
        queue_byte("A", 1'b1, 1'b0);
        queue_byte("B", 1'b0, 1'b0);
        for (t = 0; t < 3; t++)
        begin
            queue_byte("A", 1'b0, 1'b0);
            queue_byte("B", 1'b0, 1'b0);
        end
        queue_byte("C", 1'b0, 1'b1);
        // Final byte inside the skipped region
        queue_byte("A", 1'b1, 1'b1);
        // Restart with first_byte while the previous text is still inside the skipped region
        queue_byte("A", 1'b1, 1'b0);
        queue_byte("B", 1'b0, 1'b0);
        queue_byte("A", 1'b1, 1'b0);
        wait_idle();

        // Directed: length zero behaves as a one-byte pattern
        write_reg(CFG_PATTERN_LENGTH, 64'd0);
        write_reg(CFG_SKIP_COUNT, 64'd0);
        queue_byte("Z", 1'b1, 1'b0);
        queue_byte("A", 1'b0, 1'b1);
        wait_idle();

        // Random segments; each ends with a full drain before the next setting
        while (random_count < RANDOM_ITEMS)
        begin
            if (random_count < RANDOM_ITEMS / 3)
            begin
                send_gap_pct   = 6;
                recv_stall_pct = 50;
            end
            else if (random_count < 2 * RANDOM_ITEMS / 3)
            begin
                send_gap_pct   = 50;
                recv_stall_pct = 6;
            end
            else
            begin
                send_gap_pct   = 0;
                recv_stall_pct = 0;
            end
            configure_segment(seg);
            repeat ($urandom_range(3, 6))
                queue_text(random_count);
            queue_noise($urandom_range(2, 8), random_count);
            wait_idle();
            seg++;
        end

        repeat (TAIL_CYCLES) @(posedge clk);
        if (pending_results.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", pending_results.size()));

        $display("Ran %0d text bytes over %0d register writes in %0d random settings;",
                 items_sent, cfg_writes, seg);
        $display("saw %0d matches and %0d texts ending without one, %0d mismatches.",
                 hits_seen, misses_seen, error_count);
        if (error_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

/* kmp_pattern_matcher.f */
sv/kmp_pkg.sv
sv/kmp_pattern_matcher.sv
bench/kmp_pattern_matcher_test.sv
